@@ rtl/core/websocket_frame_deframer_macros.svh @@
// ----------------------------------------------------------------------------
// websocket frame deframer assertion macros
// clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication
`define WSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// wsd_pkg
// types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

	typedef enum logic [5:0] {
		PH_FIRST   = 6'b000001,
		PH_SECOND  = 6'b000010,
		PH_EXTLEN  = 6'b000100,
		PH_KEY     = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_DEAD    = 6'b100000
	} phase_t;

	typedef enum logic [2:0] {
		FT_BINARY      = 3'd0,
		FT_PART_BINARY = 3'd1,
		FT_TEXT        = 3'd2,
		FT_PART_TEXT   = 3'd3,
		FT_CLOSE       = 3'd4,
		FT_PING        = 3'd5,
		FT_PONG        = 3'd6,
		FT_ERROR       = 3'd7
	} frame_class_t;

	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
	localparam logic [6:0] LEN_CODE_16   = 7'd126;

	localparam logic [3:0] EXT_BYTES_16 = 4'd2;
	localparam logic [3:0] EXT_BYTES_64 = 4'd8;
	localparam logic [3:0] KEY_BYTES    = 4'd4;

	localparam logic [31:0] MAX_SIZE_RESET = 32'd65535;

	localparam logic RK_HEADER  = 1'b0;
	localparam logic RK_PAYLOAD = 1'b1;

	typedef struct packed {
		logic         result_kind;
		frame_class_t frame_class;
		logic [3:0]   opcode;
		logic         fin_flag;
		logic         mask_flag;
		logic [6:0]   length_code;
		logic [63:0]  payload_length;
		logic [7:0]   data_byte;
		logic         last_byte;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/core/websocket_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// parses websocket frame headers from a byte stream and unmasks the payload
// ----------------------------------------------------------------------------
// Usage: one received byte per input beat (in_valid / in_stall / in_byte).
// Each byte lands in an input register, is parsed there against the frame
// state once the queue has room and, if it yields a result, is written to
// a two-entry result queue driving the output channel (out_valid / out_stall).
// A header result follows the last header byte (second byte, last extended
// length byte or last key byte); each payload byte gives one payload result
// with last_byte set on the final one. A frame of type error stops all
// further output until reset.
// A byte passes the input register and then the result queue, whose head
// entry drives the outputs. Throughput: one byte per cycle; in_stall only
// rises while the result queue is full, so a stalled receiver stops the
// input after two results are waiting plus one byte held in the input
// register. max_message_size is written via cfg_we / cfg_wdata only while
// idle, a rule for the user that the block itself does not enforce. Reset
// clears the parser to expect a first header byte, empties the queue and
// sets max_message_size to 65535. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "websocket_frame_deframer_macros.svh"

module websocket_frame_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             result_kind,
	output logic [2:0]       frame_class,
	output logic [3:0]       opcode,
	output logic             fin_flag,
	output logic             mask_flag,
	output logic [6:0]       length_code,
	output logic [63:0]      payload_length,
	output logic [7:0]       data_byte,
	output logic             last_byte
);

	logic [31:0] max_size_q;

	logic       valid_s1;
	logic [7:0] byte_s1;

	wsd_pkg::phase_t phase_q, phase_n;
	logic [3:0]  cnt_q, cnt_n;
	logic        fin_q, fin_n;
	logic [3:0]  op_q, op_n;
	logic        mask_q, mask_n;
	logic [6:0]  lc_q, lc_n;
	logic [63:0] len_q, len_n;
	logic [31:0] key_q, key_n;
	logic [63:0] remain_q, remain_n;
	logic [1:0]  kidx_q, kidx_n;

	wsd_pkg::result_t fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fcnt_q;

	logic             advance;
	logic             emit;
	logic             do_finish;
	logic             after_len;
	wsd_pkg::result_t res;
	wsd_pkg::frame_class_t ft;
	logic             push, pop;
	logic [7:0]       kb;

	function automatic wsd_pkg::frame_class_t classify(
		input logic        fin,
		input logic [3:0]  op,
		input logic [63:0] len,
		input logic [31:0] max_size
	);
		wsd_pkg::frame_class_t t;
		if (len > {32'd0, max_size}) begin
			t = wsd_pkg::FT_ERROR;
		end else begin
			case (op)
				wsd_pkg::OP_CONT, wsd_pkg::OP_BINARY: begin
					t = fin ? wsd_pkg::FT_BINARY : wsd_pkg::FT_PART_BINARY;
				end
				wsd_pkg::OP_TEXT: begin
					t = fin ? wsd_pkg::FT_TEXT : wsd_pkg::FT_PART_TEXT;
				end
				wsd_pkg::OP_CLOSE: t = wsd_pkg::FT_CLOSE;
				wsd_pkg::OP_PING:  t = wsd_pkg::FT_PING;
				wsd_pkg::OP_PONG:  t = wsd_pkg::FT_PONG;
				default:           t = wsd_pkg::FT_ERROR;
			endcase
		end
		return t;
	endfunction

	assign advance  = valid_s1 && (fcnt_q != 2'd2);
	assign in_stall = valid_s1 && (fcnt_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= wsd_pkg::MAX_SIZE_RESET;
		end else if (cfg_we) begin
			max_size_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	assign kb = mask_q ? key_q[{kidx_q, 3'b000} +: 8] : 8'd0;

	always_comb begin
		phase_n   = phase_q;
		cnt_n     = cnt_q;
		fin_n     = fin_q;
		op_n      = op_q;
		mask_n    = mask_q;
		lc_n      = lc_q;
		len_n     = len_q;
		key_n     = key_q;
		remain_n  = remain_q;
		kidx_n    = kidx_q;
		emit      = 1'b0;
		do_finish = 1'b0;
		after_len = 1'b0;
		res       = '0;

		case (phase_q)
			wsd_pkg::PH_FIRST: begin
				fin_n   = byte_s1[7];
				op_n    = byte_s1[3:0];
				phase_n = wsd_pkg::PH_SECOND;
			end
			wsd_pkg::PH_SECOND: begin
				mask_n = byte_s1[7];
				lc_n   = byte_s1[6:0];
				if (byte_s1[6:0] <= wsd_pkg::LEN_SHORT_MAX) begin
					len_n     = {57'd0, byte_s1[6:0]};
					after_len = 1'b1;
				end else begin
					len_n   = '0;
					cnt_n   = (byte_s1[6:0] == wsd_pkg::LEN_CODE_16) ?
						wsd_pkg::EXT_BYTES_16 : wsd_pkg::EXT_BYTES_64;
					phase_n = wsd_pkg::PH_EXTLEN;
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				len_n = {len_q[55:0], byte_s1};
				cnt_n = cnt_q - 4'd1;
				if (cnt_n == 4'd0) begin
					after_len = 1'b1;
				end
			end
			wsd_pkg::PH_KEY: begin
				key_n = key_q | ({24'd0, byte_s1} << {cnt_q[1:0], 3'b000});
				cnt_n = cnt_q + 4'd1;
				if (cnt_n >= wsd_pkg::KEY_BYTES) begin
					do_finish = 1'b1;
				end
			end
			wsd_pkg::PH_PAYLOAD: begin
				emit            = 1'b1;
				res.result_kind = wsd_pkg::RK_PAYLOAD;
				res.data_byte   = byte_s1 ^ kb;
				res.last_byte   = (remain_q == 64'd1);
				kidx_n          = kidx_q + 2'd1;
				remain_n        = remain_q - 64'd1;
				if (remain_q == 64'd1) begin
					phase_n = wsd_pkg::PH_FIRST;
				end
			end
			default: begin
				// error seen: drop everything
			end
		endcase

		if (after_len) begin
			if (mask_n) begin
				cnt_n   = '0;
				key_n   = '0;
				phase_n = wsd_pkg::PH_KEY;
			end else begin
				do_finish = 1'b1;
			end
		end

		ft = classify(fin_n, op_n, len_n, max_size_q);
		if (do_finish) begin
			emit               = 1'b1;
			res.result_kind    = wsd_pkg::RK_HEADER;
			res.frame_class    = ft;
			res.opcode         = op_n;
			res.fin_flag       = fin_n;
			res.mask_flag      = mask_n;
			res.length_code    = lc_n;
			res.payload_length = len_n;
			if (ft == wsd_pkg::FT_ERROR) begin
				phase_n = wsd_pkg::PH_DEAD;
			end else if (len_n == 64'd0) begin
				phase_n = wsd_pkg::PH_FIRST;
			end else begin
				remain_n = len_n;
				kidx_n   = '0;
				phase_n  = wsd_pkg::PH_PAYLOAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsd_pkg::PH_FIRST;
			cnt_q    <= '0;
			fin_q    <= 1'b0;
			op_q     <= '0;
			mask_q   <= 1'b0;
			lc_q     <= '0;
			len_q    <= '0;
			key_q    <= '0;
			remain_q <= '0;
			kidx_q   <= '0;
		end else if (advance) begin
			phase_q  <= phase_n;
			cnt_q    <= cnt_n;
			fin_q    <= fin_n;
			op_q     <= op_n;
			mask_q   <= mask_n;
			lc_q     <= lc_n;
			len_q    <= len_n;
			key_q    <= key_n;
			remain_q <= remain_n;
			kidx_q   <= kidx_n;
		end
	end

	// two-entry result queue
	assign push = advance && emit;
	assign pop  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fcnt_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fcnt_q <= fcnt_q + 2'd1;
				2'b01:   fcnt_q <= fcnt_q - 2'd1;
				default: fcnt_q <= fcnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	assign out_valid      = (fcnt_q != 2'd0);
	assign result_kind    = fifo_q[rd_ptr_q].result_kind;
	assign frame_class    = fifo_q[rd_ptr_q].frame_class;
	assign opcode         = fifo_q[rd_ptr_q].opcode;
	assign fin_flag       = fifo_q[rd_ptr_q].fin_flag;
	assign mask_flag      = fifo_q[rd_ptr_q].mask_flag;
	assign length_code    = fifo_q[rd_ptr_q].length_code;
	assign payload_length = fifo_q[rd_ptr_q].payload_length;
	assign data_byte      = fifo_q[rd_ptr_q].data_byte;
	assign last_byte      = fifo_q[rd_ptr_q].last_byte;

	`WSD_ASSERT_NOW(a_phase_onehot, 1'b1, $onehot(phase_q), "parse phase not one-hot")
	`WSD_ASSERT_NOW(a_queue_bound, 1'b1, fcnt_q != 2'd3, "result queue overflow")
	`WSD_ASSERT_NEXT(a_dead_sticky, phase_q == wsd_pkg::PH_DEAD, phase_q == wsd_pkg::PH_DEAD,
		"left error state without reset")
	`WSD_ASSERT_NEXT(a_last_to_first,
		advance && phase_q == wsd_pkg::PH_PAYLOAD && remain_q == 64'd1,
		phase_q == wsd_pkg::PH_FIRST, "last payload beat did not end frame")

endmodule

`default_nettype wire

@@ verif/tb_websocket_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer
// self-checking bench for the websocket deframer: sends framed byte streams
// in random bursts against a randomly stalling receiver, predicts every
// header and unmasked payload beat, and compares them in order
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;
	import wsd_pkg::*;

	typedef enum logic [1:0] {LF_SHORT, LF_16, LF_64} len_form_t;

	localparam logic [6:0] LEN_CODE_64 = 7'd127;
	localparam logic [3:0] KNOWN_OPS [6] = '{OP_CONT, OP_TEXT, OP_BINARY,
		OP_CLOSE, OP_PING, OP_PONG};
	localparam int RANDOM_BYTES = 360;
	localparam int SETTLE_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        result_kind;
	logic [2:0]  frame_class;
	logic [3:0]  opcode;
	logic        fin_flag;
	logic        mask_flag;
	logic [6:0]  length_code;
	logic [63:0] payload_length;
	logic [7:0]  data_byte;
	logic        last_byte;

	websocket_frame_deframer dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser state as the block should hold it
	logic [31:0] max_size = MAX_SIZE_RESET;
	phase_t      phase = PH_FIRST;
	logic [3:0]  ext_left = '0;
	logic [3:0]  key_count = '0;
	logic        hdr_fin = 1'b0;
	logic [3:0]  hdr_op = '0;
	logic        hdr_masked = 1'b0;
	logic [6:0]  hdr_code = '0;
	logic [63:0] hdr_len = '0;
	logic [63:0] remaining = '0;
	logic [31:0] key = '0;
	logic [1:0]  key_pos = '0;

	result_t expected_results[$];
	int      fail_count = 0;
	int      bytes_fed = 0;
	int      burst_left = 0;
	int      stall_pct = 0;
	int      stall_run = 0;

	function automatic frame_class_t classify_frame();
		if (hdr_len > {32'd0, max_size}) return FT_ERROR;
		case (hdr_op)
			OP_CONT, OP_BINARY: return hdr_fin ? FT_BINARY : FT_PART_BINARY;
			OP_TEXT: return hdr_fin ? FT_TEXT : FT_PART_TEXT;
			OP_CLOSE: return FT_CLOSE;
			OP_PING: return FT_PING;
			OP_PONG: return FT_PONG;
			default: return FT_ERROR;
		endcase
	endfunction

	function automatic void close_header();
		result_t r;
		r = '0;
		r.result_kind = RK_HEADER;
		r.frame_class = classify_frame();
		r.opcode = hdr_op;
		r.fin_flag = hdr_fin;
		r.mask_flag = hdr_masked;
		r.length_code = hdr_code;
		r.payload_length = hdr_len;
		expected_results.push_back(r);
		if (r.frame_class == FT_ERROR) begin
			phase = PH_DEAD;
		end else if (hdr_len == 0) begin
			phase = PH_FIRST;
		end else begin
			remaining = hdr_len;
			key_pos = '0;
			phase = PH_PAYLOAD;
		end
	endfunction

	function automatic void length_done();
		if (hdr_masked) begin
			key_count = '0;
			key = '0;
			phase = PH_KEY;
		end else begin
			close_header();
		end
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		result_t r;
		logic [7:0] kb;
		case (phase)
			PH_FIRST: begin
				hdr_fin = b[7];
				hdr_op = b[3:0];
				phase = PH_SECOND;
			end
			PH_SECOND: begin
				hdr_masked = b[7];
				hdr_code = b[6:0];
				hdr_len = '0;
				if (hdr_code <= LEN_SHORT_MAX) begin
					hdr_len = {57'd0, hdr_code};
					length_done();
				end else begin
					ext_left = (hdr_code == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
					phase = PH_EXTLEN;
				end
			end
			PH_EXTLEN: begin
				hdr_len = {hdr_len[55:0], b};
				ext_left = ext_left - 4'd1;
				if (ext_left == 0) length_done();
			end
			PH_KEY: begin
				key[8*key_count[1:0] +: 8] = b;
				key_count = key_count + 4'd1;
				if (key_count >= KEY_BYTES) close_header();
			end
			PH_PAYLOAD: begin
				kb = hdr_masked ? key[8*key_pos +: 8] : 8'h00;
				r = '0;
				r.result_kind = RK_PAYLOAD;
				r.data_byte = b ^ kb;
				r.last_byte = (remaining == 64'd1);
				expected_results.push_back(r);
				key_pos = key_pos + 2'd1;
				remaining = remaining - 64'd1;
				if (remaining == 0) phase = PH_FIRST;
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result beat: kind %0d", result_kind);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("result_kind", 64'(want.result_kind), 64'(result_kind));
				check_field("frame_class", 64'(want.frame_class), 64'(frame_class));
				check_field("opcode", 64'(want.opcode), 64'(opcode));
				check_field("fin_flag", 64'(want.fin_flag), 64'(fin_flag));
				check_field("mask_flag", 64'(want.mask_flag), 64'(mask_flag));
				check_field("length_code", 64'(want.length_code), 64'(length_code));
				check_field("payload_length", want.payload_length, payload_length);
				check_field("data_byte", 64'(want.data_byte), 64'(data_byte));
				check_field("last_byte", 64'(want.last_byte), 64'(last_byte));
			end
		end
	end

	// receiver backpressure: the stall density (0, 25, 50 or 75 percent) is redrawn after each random run
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_pct = 25 * $urandom_range(0, 3);
			stall_run = $urandom_range(8, 64);
		end
		stall_run--;
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk) in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (in_stall);
		if (phase != PH_DEAD) bytes_fed++;
		deframe_byte(b);
	endtask

	task automatic drain_results();
		@(negedge clk) in_valid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0) @(posedge clk);
		// header bytes give no result, so let the pipeline settle too
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_size(input logic [31:0] v);
		drain_results();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		max_size = v;
	endtask

	task automatic send_header(input logic fin, input logic [3:0] op, input logic masked,
			input len_form_t form, input logic [63:0] len);
		logic [2:0] rsv;
		logic [6:0] code;
		int n_ext;
		rsv = 3'($urandom_range(0, 7));
		code = (form == LF_SHORT) ? len[6:0] : (form == LF_16) ? LEN_CODE_16 : LEN_CODE_64;
		n_ext = (form == LF_SHORT) ? 0 :
			(form == LF_16) ? int'(EXT_BYTES_16) : int'(EXT_BYTES_64);
		send_byte({fin, rsv, op});
		send_byte({masked, code});
		for (int i = n_ext - 1; i >= 0; i--) send_byte(len[8*i +: 8]);
		if (masked) repeat (KEY_BYTES) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
			input len_form_t form, input logic [63:0] len);
		send_header(fin, op, masked, form, len);
		repeat (len) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_random_frame();
		int unsigned cap;
		logic [63:0] len;
		len_form_t form;
		cap = ($urandom_range(0, 9) == 0) ? 300 : 12;
		if (max_size < cap) cap = max_size;
		len = 64'($urandom_range(0, cap));
		if (len > LEN_SHORT_MAX) begin
			form = ($urandom_range(0, 1) == 0) ? LF_16 : LF_64;
		end else begin
			case ($urandom_range(0, 4))
				0: form = LF_16;
				1: form = LF_64;
				default: form = LF_SHORT;
			endcase
		end
		send_frame(1'($urandom_range(0, 1)), KNOWN_OPS[$urandom_range(0, 5)],
			1'($urandom_range(0, 1)), form, len);
	endtask

	task automatic test_frame_types();
		// header only, the next byte opens a new frame
		send_frame(1'b1, OP_TEXT, 1'b0, LF_SHORT, 64'd0);
		for (int i = 0; i < $size(KNOWN_OPS); i++) begin
			send_frame(1'b0, KNOWN_OPS[i], 1'b0, LF_SHORT, 64'd1);
			send_frame(1'b1, KNOWN_OPS[i], 1'b1, LF_SHORT, 64'd5);
		end
		send_frame(1'b1, OP_BINARY, 1'b1, LF_SHORT, 64'(LEN_SHORT_MAX));
		send_frame(1'b1, OP_TEXT, 1'b0, LF_16, 64'd3);
		send_frame(1'b0, OP_BINARY, 1'b1, LF_64, 64'd6);
	endtask

	task automatic test_max_size_limits();
		write_max_size(32'd0);
		send_frame(1'b1, OP_PING, 1'b1, LF_16, 64'd0);
		send_frame(1'b1, OP_CLOSE, 1'b0, LF_64, 64'd0);
		write_max_size(32'hFFFF_FFFF);
		send_frame(1'b1, OP_BINARY, 1'b1, LF_64, 64'd9);
		// length equal to the limit is still accepted
		write_max_size(32'd7);
		send_frame(1'b0, OP_CONT, 1'b1, LF_16, 64'd7);
	endtask

	task automatic test_random_traffic();
		int start;
		int phase_start;
		start = bytes_fed;
		while (bytes_fed - start < RANDOM_BYTES) begin
			case ($urandom_range(0, 4))
				0: write_max_size(32'd0);
				1: write_max_size($urandom_range(1, 40));
				2: write_max_size(MAX_SIZE_RESET);
				3: write_max_size(32'hFFFF_FFFF);
				default: write_max_size($urandom);
			endcase
			phase_start = bytes_fed;
			while (bytes_fed - phase_start < 120) send_random_frame();
		end
	endtask

	// an error frame locks the parser until reset, so this runs last
	task automatic test_error_lockout();
		logic [3:0] op;
		logic [31:0] limit;
		logic [63:0] len;
		case ($urandom_range(0, 2))
			0: begin
				op = ($urandom_range(0, 1) == 0) ?
					4'($urandom_range(OP_BINARY + 1, OP_CLOSE - 1)) :
					4'($urandom_range(OP_PONG + 1, 15));
				send_header(1'($urandom_range(0, 1)), op, 1'($urandom_range(0, 1)),
					LF_SHORT, 64'($urandom_range(0, LEN_SHORT_MAX)));
			end
			1: begin
				limit = $urandom_range(0, 1000);
				write_max_size(limit);
				send_header(1'b1, OP_TEXT, 1'($urandom_range(0, 1)), LF_16,
					64'(limit) + 64'd1);
			end
			default: begin
				// 64-bit length with the top bit set
				len = {$urandom, $urandom};
				len[63] = 1'b1;
				send_header(1'b1, OP_BINARY, 1'b1, LF_64, len);
			end
		endcase
		repeat (24) send_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_frame_types();
		test_max_size_limits();
		test_random_traffic();
		test_error_lockout();
		drain_results();
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
